// ===== rtl/pol_pkg.sv =====
// Shared types and constants for the positional ordered list core.
// Command and status codes, cell control bundle, list geometry.
// No dependencies.
`default_nettype none

package pol_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int LEN_W      = $clog2(CAPACITY + 1);
    localparam int POS_W      = 6;
    localparam int VAL_W      = 32;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;

    localparam logic [VAL_W-1:0] GET_MISS = 32'h7FFF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_END   = 3'd1,
        CMD_INSERT_AT = 3'd2,
        CMD_SEARCH    = 3'd3,
        CMD_DEL_FRONT = 3'd4,
        CMD_DEL_END   = 3'd5,
        CMD_DEL_AT    = 3'd6,
        CMD_GET       = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      idx;
        logic [DATA_WIDTH-1:0] value;
        logic [LEN_W-1:0]      len;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/pol_cell.sv =====
// One storage cell of the list chain: holds one entry, shifts to/from neighbors.
// Depends on pol_pkg.
`default_nettype none

module pol_cell (
    input  wire logic                          aclk,
    input  wire logic                          apply,
    input  wire pol_pkg::cell_ctrl_t           ctrl,
    input  wire logic [pol_pkg::IDX_W-1:0]     cell_idx,
    input  wire logic [pol_pkg::DATA_WIDTH-1:0] left_data,
    input  wire logic [pol_pkg::DATA_WIDTH-1:0] right_data,
    output logic      [pol_pkg::DATA_WIDTH-1:0] data_out,
    output logic      [pol_pkg::DATA_WIDTH-1:0] rd_data,
    output logic                               match
);
    import pol_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                // shift right behind the slot, write the new value at the slot
                if (cell_idx == ctrl.idx) begin
                    data_next = ctrl.value;
                end else if (cell_idx > ctrl.idx) begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE: begin
                // close the gap: take the right neighbor from the slot on
                if (cell_idx >= ctrl.idx) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (apply) begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;
    assign rd_data  = (cell_idx == ctrl.idx) ? data_reg : '0;
    assign match    = (data_reg == ctrl.value) && ({1'b0, cell_idx} < ctrl.len);

endmodule

`default_nettype wire

// ===== rtl/positional_ordered_list_core.sv =====
// Positional ordered list core: a chain of pol_cell entries with a command sequencer.
// A captured command executes into the output register; a waiting result stalls it.
// The sequencer executes one command at a time and takes none while one executes.
// The output register lets the next command be taken while a result still waits.
// Reset (aresetn low, synchronous) empties the list and drops any pending result.
// Cell contents are not reset; only slots below the length are ever read.
`default_nettype none

module positional_ordered_list_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: position[5:0], value[37:6], zero fill [39:38]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // s_tuser: cmd[2:0]
    input  wire logic [2:0]  s_tuser,
    // m_tdata: found_position[5:0], item_value[37:6], count[43:38], zero fill [47:44]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,
    // m_tuser: status[1:0]
    output logic      [1:0]  m_tuser
);
    import pol_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    // captured command
    cmd_t              cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;

    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;

    // output register
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_found_reg;
    logic [VAL_W-1:0]  out_item_reg;
    status_t           out_status_reg;
    logic [LEN_W-1:0]  out_count_reg;

    logic [POS_W-1:0]  found_next;
    logic [VAL_W-1:0]  item_next;
    status_t           status_next;

    logic              slot_free;
    logic              apply;
    cell_ctrl_t        ctrl;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;
    logic [DATA_WIDTH-1:0] rd_or;

    logic [POS_W-1:0] pos_m1;
    logic [LEN_W-1:0] len_m1;
    logic [POS_W-1:0] ins_pos;

    assign s_tready  = (state_reg == S_IDLE);
    // result slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || m_tready;
    assign apply     = (state_reg == S_EXEC) && slot_free;

    assign pos_m1  = pos_reg - POS_W'(1);
    assign len_m1  = length_reg - LEN_W'(1);
    // insert target: position 0 or 1 goes to the front, past the end appends
    assign ins_pos = (pos_reg <= POS_W'(1)) ? '0 :
                     ((pos_m1 > length_reg) ? length_reg : pos_m1);

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        pol_cell u_cell (
            .aclk       (aclk),
            .apply      (apply),
            .ctrl       (ctrl),
            .cell_idx   (IDX_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_data[i]),
            .rd_data    (cell_rd[i]),
            .match      (cell_match[i])
        );
    end

    // merge the single addressed cell for get
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    // command decode: cell control, result fields and new length
    always_comb begin
        ctrl.op     = CELL_HOLD;
        ctrl.idx    = '0;
        ctrl.value  = val_reg[DATA_WIDTH-1:0];
        ctrl.len    = length_reg;
        length_next = length_reg;
        found_next  = '0;
        item_next   = '0;
        status_next = STAT_OK;

        case (cmd_reg)
            CMD_ADD_FRONT, CMD_ADD_END, CMD_INSERT_AT: begin
                if (length_reg == LEN_W'(CAPACITY)) begin
                    status_next = STAT_FULL;
                end else begin
                    ctrl.op     = CELL_INSERT;
                    length_next = length_reg + LEN_W'(1);
                    if (cmd_reg == CMD_ADD_FRONT) begin
                        ctrl.idx = '0;
                    end else if (cmd_reg == CMD_ADD_END) begin
                        ctrl.idx = length_reg[IDX_W-1:0];
                    end else begin
                        ctrl.idx = ins_pos[IDX_W-1:0];
                    end
                end
            end
            CMD_SEARCH: begin
                if (length_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else begin
                    // first match wins: scan from the back so the lowest index sticks
                    for (int i = CAPACITY - 1; i >= 0; i--) begin
                        if (cell_match[i]) begin
                            found_next = POS_W'(i + 1);
                        end
                    end
                end
            end
            CMD_DEL_FRONT: begin
                if (length_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else begin
                    ctrl.op     = CELL_REMOVE;
                    ctrl.idx    = '0;
                    length_next = len_m1;
                end
            end
            CMD_DEL_END: begin
                if (length_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else begin
                    ctrl.op     = CELL_REMOVE;
                    ctrl.idx    = len_m1[IDX_W-1:0];
                    length_next = len_m1;
                end
            end
            CMD_DEL_AT: begin
                if (length_reg == '0) begin
                    status_next = STAT_EMPTY;
                end else if (pos_reg == '0 || pos_reg > length_reg) begin
                    status_next = STAT_RANGE;
                end else begin
                    ctrl.op     = CELL_REMOVE;
                    ctrl.idx    = pos_m1[IDX_W-1:0];
                    length_next = len_m1;
                end
            end
            default: begin
                // get
                ctrl.idx = pos_m1[IDX_W-1:0];
                if (pos_reg == '0 || pos_reg > length_reg) begin
                    item_next   = GET_MISS;
                    status_next = STAT_RANGE;
                end else begin
                    item_next = VAL_W'(rd_or);
                end
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // capture the command transaction
            if (s_tvalid && s_tready) begin
                cmd_reg <= cmd_t'(s_tuser);
                pos_reg <= s_tdata[POS_W-1:0];
                val_reg <= s_tdata[POS_W+VAL_W-1:POS_W];
            end
            // drop a taken result, load a new one when the command executes
            if (apply) begin
                out_valid_reg  <= 1'b1;
                out_found_reg  <= found_next;
                out_item_reg   <= item_next;
                out_status_reg <= status_next;
                out_count_reg  <= length_next;
                length_reg     <= length_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_item_reg, out_found_reg};
    assign m_tuser  = out_status_reg;

`ifndef ASSERT_OFF
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_len_only_on_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        !apply |=> length_reg == $past(length_reg))
        else $error("length changed without an executed command");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status_reg == STAT_FULL |-> out_count_reg == LEN_W'(CAPACITY))
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_status_reg == STAT_EMPTY |-> out_count_reg == '0)
        else $error("empty status with entries present");

    a_found_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_found_reg <= out_count_reg)
        else $error("search position beyond list end");
`endif

endmodule

`default_nettype wire
